// ===== hw/rtl/lzwe_pkg.sv =====
`timescale 1ns / 1ps

package lzwe_pkg;

  localparam int CODE_BITS_DEF  = 12;
  localparam int HASH_DEPTH_DEF = 8192;
  localparam int BYTE_W         = 8;
  localparam int OUT_W          = 12;
  localparam int FIRST_FREE     = 256;

  // Hash mixing constants
  localparam logic [31:0] HASH_MUL_A = 32'd2654435761;
  localparam logic [31:0] HASH_MUL_B = 32'd40503;
  localparam int          HASH_SHIFT = 7;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_EMIT0,
    S_EMITL
  } lzwe_state_t;

endpackage

// ===== hw/rtl/lzw_encoder_core.sv =====
`timescale 1ns / 1ps

// LZW encoder core. Takes one byte per input item and emits 12-bit codes
// (literals 0-255, dictionary codes from 256 up to 2**CODE_BITS-1); the
// item flagged end_of_stream flushes the pending prefix and its code
// carries last_code. The dictionary is a linear-probed hash table in one
// single-port-read / single-port-write RAM of HASH_DEPTH entries
// (HASH_DEPTH must be a power of two). Each byte passes through accept,
// RAM read and compare when the first probe answers, with one more read
// and compare per extra probe after a collision, and an emit state for
// each emitted code (held while out_stall holds the output register).
// After reset and after every end-of-stream item the core sweeps the
// table empty, one entry per cycle, while in_stall stays high. Once
// 2**CODE_BITS codes are handed out, or the table is full, coding goes
// on without new entries.
module lzw_encoder_core import lzwe_pkg::*; #(
  parameter int CODE_BITS  = CODE_BITS_DEF,
  parameter int HASH_DEPTH = HASH_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input item channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_end_of_stream,
  // result item channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  out_code,
  output logic              out_last_code
);

  localparam int HB     = $clog2(HASH_DEPTH);
  localparam int CW     = CODE_BITS;
  localparam int EW     = 1 + 2 * CW + BYTE_W;   // valid, key prefix, key byte, code
  localparam int WIDE_W = (CW > OUT_W) ? CW : OUT_W;

  lzwe_state_t state_r, state_nxt;

  logic [CW-1:0]     prefix_r, prefix_nxt;
  logic              present_r, present_nxt;
  logic [CW:0]       next_free_r, next_free_nxt;   // MSB set: code space used up
  logic [HB-1:0]     slot_r, slot_nxt;             // probe slot, also clear address
  logic [HB-1:0]     probes_r, probes_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              eos_r, eos_nxt;

  logic              out_valid_r;
  logic [OUT_W-1:0]  out_code_r;
  logic              out_last_r;
  logic              out_free;
  logic              out_load;
  logic              load_last;
  logic [WIDE_W-1:0] prefix_wide;

  logic [HB-1:0]     hash_slot;
  logic              wr_en;
  logic [EW-1:0]     wr_data;
  logic              rd_en;
  logic [EW-1:0]     rd_data;

  logic              rd_valid;
  logic [CW-1:0]     rd_prefix;
  logic [BYTE_W-1:0] rd_byte;
  logic [CW-1:0]     rd_value;
  logic              rd_match;

  lzwe_hash #(
    .CODE_BITS (CW),
    .HASH_BITS (HB)
  ) u_hash (
    .prefix    (prefix_r),
    .data_byte (in_data_byte),
    .slot      (hash_slot)
  );

  // Outside the clear sweep only S_CHECK writes, and the next read comes only
  // after the emit and idle states, so reads never race a write to the same entry.
  lzwe_dict_ram #(
    .ADDR_W (HB),
    .DATA_W (EW)
  ) u_dict (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (slot_r),
    .rd_data (rd_data)
  );

  // entry unpack
  assign rd_valid  = rd_data[EW-1];
  assign rd_prefix = rd_data[EW-2 -: CW];
  assign rd_byte   = rd_data[CW +: BYTE_W];
  assign rd_value  = rd_data[CW-1:0];
  assign rd_match  = rd_valid && (rd_prefix == prefix_r) && (rd_byte == byte_r);

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    prefix_nxt    = prefix_r;
    present_nxt   = present_r;
    next_free_nxt = next_free_r;
    slot_nxt      = slot_r;
    probes_nxt    = probes_r;
    byte_nxt      = byte_r;
    eos_nxt       = eos_r;
    wr_en         = 1'b0;
    wr_data       = '0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    load_last     = 1'b0;

    unique case (state_r)
      // sweep table empty
      S_CLEAR: begin
        wr_en    = 1'b1;
        slot_nxt = slot_r + HB'(1);
        if (&slot_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_data_byte;
          eos_nxt  = in_end_of_stream;
          if (present_r) begin
            slot_nxt   = hash_slot;
            probes_nxt = '0;
            state_nxt  = S_READ;
          end else begin
            // first byte of a stream just becomes the prefix
            prefix_nxt  = CW'(in_data_byte);
            present_nxt = 1'b1;
            if (in_end_of_stream) begin
              state_nxt = S_EMITL;
            end
          end
        end
      end

      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        if (rd_match) begin
          prefix_nxt = rd_value;
          state_nxt  = eos_r ? S_EMITL : S_IDLE;
        end else if (!rd_valid) begin
          // empty slot: miss, insert while codes remain
          if (!next_free_r[CW]) begin
            wr_en         = 1'b1;
            wr_data       = {1'b1, prefix_r, byte_r, next_free_r[CW-1:0]};
            next_free_nxt = next_free_r + (CW+1)'(1);
          end
          state_nxt = S_EMIT0;
        end else if (&probes_r) begin
          // whole table probed: miss, no room
          state_nxt = S_EMIT0;
        end else begin
          slot_nxt   = slot_r + HB'(1);
          probes_nxt = probes_r + HB'(1);
          state_nxt  = S_READ;
        end
      end

      // emit old prefix, byte starts the new string
      S_EMIT0: begin
        if (out_free) begin
          out_load   = 1'b1;
          prefix_nxt = CW'(byte_r);
          state_nxt  = eos_r ? S_EMITL : S_IDLE;
        end
      end

      // flush final code, restart dictionary
      S_EMITL: begin
        if (out_free) begin
          out_load      = 1'b1;
          load_last     = 1'b1;
          prefix_nxt    = '0;
          present_nxt   = 1'b0;
          next_free_nxt = (CW+1)'(FIRST_FREE);
          slot_nxt      = '0;
          state_nxt     = S_CLEAR;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      prefix_r    <= '0;
      present_r   <= 1'b0;
      next_free_r <= (CW+1)'(FIRST_FREE);
      slot_r      <= '0;
      probes_r    <= '0;
      eos_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prefix_r    <= prefix_nxt;
      present_r   <= present_nxt;
      next_free_r <= next_free_nxt;
      slot_r      <= slot_nxt;
      probes_r    <= probes_nxt;
      eos_r       <= eos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  // output register: code is the prefix masked/extended to 12 bits
  assign prefix_wide = WIDE_W'(prefix_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_code_r <= prefix_wide[OUT_W-1:0];
      out_last_r <= load_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_code      = out_code_r;
  assign out_last_code = out_last_r;

endmodule

// ===== hw/rtl/lzwe_hash.sv =====
`timescale 1ns / 1ps

module lzwe_hash import lzwe_pkg::*; #(
  parameter int CODE_BITS = CODE_BITS_DEF,
  parameter int HASH_BITS = 13
) (
  input  logic [CODE_BITS-1:0] prefix,
  input  logic [BYTE_W-1:0]    data_byte,
  output logic [HASH_BITS-1:0] slot
);

  logic [31:0]          pfx_ext;
  logic [HASH_BITS-1:0] mul_a;
  logic [HASH_BITS-1:0] mul_b;
  logic [HASH_BITS-1:0] shr;

  assign pfx_ext = 32'(prefix);

  // Only the low HASH_BITS of each product survive the modulo.
  assign mul_a = pfx_ext[HASH_BITS-1:0] * HASH_MUL_A[HASH_BITS-1:0];
  assign mul_b = HASH_BITS'(data_byte) * HASH_MUL_B[HASH_BITS-1:0];
  assign shr   = pfx_ext[HASH_SHIFT +: HASH_BITS];

  assign slot = mul_a ^ mul_b ^ shr;

endmodule

// ===== hw/rtl/lzwe_dict_ram.sv =====
`timescale 1ns / 1ps

module lzwe_dict_ram #(
  parameter int ADDR_W = 13,
  parameter int DATA_W = 33
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/lzwe_checker.sv =====
`timescale 1ns / 1ps

module lzwe_checker import lzwe_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_end_of_stream,
  input logic              out_valid,
  input logic              out_stall,
  input logic [OUT_W-1:0]  out_code,
  input logic              out_last_code
);

  // a fresh result is only loaded while the core is busy
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while core idle");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_code) && $stable(out_last_code)))
    else $error("stalled result changed");

  // an end-of-stream item keeps the core busy: probe or flush, then the sweep
  a_eos_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_end_of_stream) |=> in_stall [*2])
    else $error("core idle right after end of stream");

endmodule

bind lzw_encoder_core lzwe_checker u_lzwe_checker (.*);

// ===== dv/tb_lzw_encoder_core.sv =====
`timescale 1ns / 1ps

module tb_lzw_encoder_core;
  import lzwe_pkg::*;

  // Small dictionary: 10-bit codes in a 512-slot table. The table fills up
  // inside one long stream, so coding on a full table (probe wraps through
  // every slot, no insert) is reached in a short run.
  localparam int CODE_W       = 10;
  localparam int TBL_DEPTH    = 512;
  localparam int BYTES_WANTED = 1600;
  // Worst quiet stretch: a full-table probe (a read and a compare per slot) or
  // the sweep after end of stream, plus receiver hold-offs.
  localparam int DRAIN_CYCLES = 3 * TBL_DEPTH;
  localparam int WD_LIMIT     = 20000;
  localparam int MAX_PRINTS   = 200;

  // One byte item plus an optional hand-typed expected code (single-byte
  // streams only, where the answer is obvious).
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              eos;
    logic              typed;
    logic [OUT_W-1:0]  code;
  } byte_row_t;

  typedef struct packed {
    logic [OUT_W-1:0] code;
    logic             last;
  } code_item_t;

  // Directed part: extremes of the byte, the classic ABABABA string, a
  // run of one repeated byte, end of stream on a miss (two codes) and end
  // of stream on a hit.
  localparam byte_row_t DIR_TBL [21] = '{
    '{8'h00, 1'b1, 1'b1, 12'h000},  // lone byte right after reset
    '{8'hFF, 1'b1, 1'b1, 12'h0FF},
    '{8'h41, 1'b0, 1'b0, 12'h000},
    '{8'h42, 1'b0, 1'b0, 12'h000},
    '{8'h41, 1'b0, 1'b0, 12'h000},
    '{8'h42, 1'b0, 1'b0, 12'h000},
    '{8'h41, 1'b0, 1'b0, 12'h000},
    '{8'h42, 1'b0, 1'b0, 12'h000},
    '{8'h41, 1'b1, 1'b0, 12'h000},
    '{8'hFF, 1'b0, 1'b0, 12'h000},  // repeated byte, string-char-string case
    '{8'hFF, 1'b0, 1'b0, 12'h000},
    '{8'hFF, 1'b0, 1'b0, 12'h000},
    '{8'hFF, 1'b1, 1'b0, 12'h000},
    '{8'h00, 1'b0, 1'b0, 12'h000},
    '{8'h01, 1'b1, 1'b0, 12'h000},  // miss on the last byte: two codes
    '{8'h00, 1'b0, 1'b0, 12'h000},
    '{8'h01, 1'b0, 1'b0, 12'h000},
    '{8'h00, 1'b0, 1'b0, 12'h000},
    '{8'h01, 1'b1, 1'b0, 12'h000},  // hit on the last byte: one code
    '{8'h80, 1'b1, 1'b1, 12'h080},
    '{8'h7F, 1'b1, 1'b1, 12'h07F}
  };

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_data_byte     = '0;
  logic              in_end_of_stream = 1'b0;
  logic              out_valid;
  logic              out_stall        = 1'b0;
  logic [OUT_W-1:0]  out_code;
  logic              out_last_code;

  byte_row_t  byte_feed[$];      // bytes not yet accepted, head is on the bus
  code_item_t pending_codes[$];  // codes still owed by the encoder
  code_item_t step_codes[$];     // codes caused by the latest byte
  int         bytes_taken = 0;
  int         err_cnt     = 0;

  // Mirror of the encoder: open-addressed dictionary plus prefix state.
  bit          dict_used [TBL_DEPTH];
  int unsigned dict_pfx  [TBL_DEPTH];
  int unsigned dict_chr  [TBL_DEPTH];
  int unsigned dict_code [TBL_DEPTH];
  int unsigned free_code;
  int unsigned cur_prefix;
  bit          have_prefix;

  lzw_encoder_core #(
    .CODE_BITS (CODE_W),
    .HASH_DEPTH(TBL_DEPTH)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_end_of_stream(in_end_of_stream),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code        (out_code),
    .out_last_code   (out_last_code)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("%0t ns: mismatch %0d: %s", $time, err_cnt, msg);
  endtask

  function automatic void dict_clear();
    for (int i = 0; i < TBL_DEPTH; i++) dict_used[i] = 1'b0;
    free_code   = FIRST_FREE;
    cur_prefix  = 0;
    have_prefix = 1'b0;
  endfunction

  function automatic int unsigned dict_home(input int unsigned pfx, input int unsigned chr);
    bit [31:0] h;
    h = (pfx * 32'd2654435761) ^ (chr * 32'd40503) ^ (pfx >> 7);
    return h % TBL_DEPTH;
  endfunction

  // Linear probe from the home slot; stops on an empty slot, a match, or
  // after visiting every slot (full table, neither hit nor room).
  function automatic void dict_search(input int unsigned pfx, input int unsigned chr,
                                      output int unsigned slot, output bit hit,
                                      output bit room);
    int unsigned s;
    int          n;
    s    = dict_home(pfx, chr);
    n    = 0;
    hit  = 1'b0;
    room = 1'b0;
    slot = 0;
    while (n < TBL_DEPTH && !hit && !room) begin
      if (!dict_used[s]) begin
        room = 1'b1;
        slot = s;
      end else if (dict_pfx[s] == pfx && dict_chr[s] == chr) begin
        hit  = 1'b1;
        slot = s;
      end else begin
        s = (s + 1) % TBL_DEPTH;
      end
      n++;
    end
  endfunction

  // Advance the mirror by one byte; the codes it causes land in step_codes.
  function automatic void lzw_predict(input logic [BYTE_W-1:0] b, input logic eos);
    int unsigned slot;
    bit          hit;
    bit          room;
    code_item_t  c;
    step_codes.delete();
    if (!have_prefix) begin
      cur_prefix  = b;
      have_prefix = 1'b1;
    end else begin
      dict_search(cur_prefix, b, slot, hit, room);
      if (hit) begin
        cur_prefix = dict_code[slot];
      end else begin
        c.code = OUT_W'(cur_prefix);
        c.last = 1'b0;
        step_codes = {step_codes, c};
        if (room && free_code < (1 << CODE_W)) begin
          dict_used[slot] = 1'b1;
          dict_pfx[slot]  = cur_prefix;
          dict_chr[slot]  = b;
          dict_code[slot] = free_code;
          free_code++;
        end
        cur_prefix = b;
      end
    end
    if (eos) begin
      c.code = OUT_W'(cur_prefix);
      c.last = 1'b1;
      step_codes = {step_codes, c};
      dict_clear();
    end
  endfunction

  // Sender: bursts of random length with random gaps (sometimes none).
  // A stalled item is held untouched; the next one is picked only after
  // an acceptance or while idle.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    bit         offer;
    code_item_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        lzw_predict(in_data_byte, in_end_of_stream);
        if (byte_feed[0].typed) begin
          c.code = byte_feed[0].code;
          c.last = 1'b1;
          pending_codes = {pending_codes, c};
        end else begin
          pending_codes = {pending_codes, step_codes};
        end
        byte_feed.pop_front();
        bytes_taken++;
        if (burst_left > 0) burst_left--;
      end
      if (!in_valid || !in_stall) begin
        offer = 1'b0;
        if (byte_feed.size() > 0) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
          if (gap_left > 0) gap_left--;
          else offer = 1'b1;
        end
        in_valid <= offer;
        if (offer) begin
          in_data_byte     <= byte_feed[0].data;
          in_end_of_stream <= byte_feed[0].eos;
        end
      end
    end
  end

  // Receiver: stall pattern switches between modes every so often. Twice
  // in the run it holds off for a long stretch so the encoder backs up
  // and stalls its input.
  int       hold_left = 0;
  int       mode      = 0;
  int       mode_left = 0;
  bit [1:0] hold_done = '0;

  always @(posedge clk) begin
    bit stall;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done[0] && bytes_taken >= 300) begin
        hold_done[0] = 1'b1;
        hold_left    = 400;
      end
      if (!hold_done[1] && bytes_taken >= 1100) begin
        hold_done[1] = 1'b1;
        hold_left    = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          0:       stall = 1'b0;                        // free running
          1:       stall = ($urandom_range(0, 3) == 0);  // light
          2:       stall = ($urandom_range(0, 3) != 0);  // heavy
          default: stall = ~out_stall;                   // alternating
        endcase
      end
      out_stall <= stall;
    end
  end

  // Code checker: every accepted code against the oldest one owed.
  always @(posedge clk) begin
    code_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_codes.size() == 0) begin
        report_mismatch($sformatf("unexpected code %0d last_code %0b", out_code,
                                  out_last_code));
      end else begin
        want = pending_codes.pop_front();
        if (out_code !== want.code)
          report_mismatch($sformatf("code %0d, want %0d", out_code, want.code));
        if (out_last_code !== want.last)
          report_mismatch($sformatf("last_code %0b, want %0b (code %0d)", out_last_code,
                                    want.last, want.code));
      end
    end
  end

  // Watchdog: too long without any item moving on either side.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WD_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb_lzw_encoder_core NOT OK");
    $finish;
  end

  initial begin
    byte_row_t r;
    int        stream_no;
    int        len;
    int        pick;
    bit        uniform;
    int        alpha;
    int        base;

    foreach (DIR_TBL[i]) byte_feed = {byte_feed, DIR_TBL[i]};

    // Random streams. One long stream of random bytes fills the table and
    // keeps coding on it when full; one long low-entropy stream builds long
    // strings. The rest are short: noise, random bytes, small alphabets.
    stream_no = 0;
    while (byte_feed.size() < BYTES_WANTED) begin
      alpha = $urandom_range(1, 4);
      base  = $urandom_range(0, 255);
      if (stream_no == 3) begin
        uniform = 1'b1;
        len     = 650;
      end else if (stream_no == 9) begin
        uniform = 1'b0;
        alpha   = 3;
        len     = 400;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          uniform = 1'b1;
          len     = $urandom_range(1, 3);
        end else if (pick < 6) begin
          uniform = 1'b1;
          len     = $urandom_range(4, 30);
        end else begin
          uniform = 1'b0;
          len     = $urandom_range(4, 60);
        end
      end
      for (int k = 0; k < len; k++) begin
        r.data  = uniform ? 8'($urandom_range(0, 255))
                          : 8'(base + $urandom_range(0, alpha - 1));
        r.eos   = (k == len - 1);
        r.typed = 1'b0;
        r.code  = '0;
        byte_feed = {byte_feed, r};
      end
      stream_no++;
    end

    dict_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_feed.size() != 0 || pending_codes.size() != 0) @(posedge clk);
    // Any stray code after the last one owed is flagged by the checker.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("tb_lzw_encoder_core OK");
    end else begin
      $display("tb_lzw_encoder_core NOT OK");
    end
    $finish;
  end

endmodule
